@@ hdl/sft_pkg.sv @@
`default_nettype none

package sft_pkg;

  localparam int DEF_MAX_TERMS = 64;
  localparam int DEF_MAX_DIM   = 64;

  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int VAL_W      = 32;
  localparam int NUM_COLS_W = 7;

  // row, col, value packed from the lowest bit up
  localparam int WORD_W  = ROW_W + COL_W + VAL_W;
  localparam int TDATA_W = ((WORD_W + 7) / 8) * 8;

  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = NUM_COLS_W'(64);

endpackage

`default_nettype wire

@@ hdl/sparse_fast_transpose_top.sv @@
`default_nettype none

// Sparse matrix fast transpose. Triplets (row, col, value) of one matrix stream in, tlast on
// the final one. Each word has its column count read, then updated if kept, and the input
// side takes no new word until that update is done. After tlast the block runs a running
// sum over the column table, scatters each kept entry to its transposed place (entry read,
// column read, write), then streams the result words out (read, load, handshake when the
// sink is ready), and clears the column table. in_tready is low from tlast until that clear
// is over. All of it goes through three single-port-read RAMs of MAX_TERMS or MAX_DIM
// entries. Entries with a column at or beyond num_cols (capped at MAX_DIM), or beyond
// MAX_TERMS held, are dropped.
module sparse_fast_transpose_top #(
  parameter int MAX_TERMS = sft_pkg::DEF_MAX_TERMS,
  parameter int MAX_DIM   = sft_pkg::DEF_MAX_DIM
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [sft_pkg::NUM_COLS_W-1:0]     cfg_wr_data,  // num_cols
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // entry_row, entry_col, entry_value, zero pad
  input  wire logic [sft_pkg::TDATA_W-1:0]        in_tdata,
  input  wire logic                               in_tlast,     // last_entry
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_row, out_col, out_value, zero pad
  output logic      [sft_pkg::TDATA_W-1:0]        out_tdata,
  output logic                                    out_tlast     // out_last
);

  localparam int ROW_W  = sft_pkg::ROW_W;
  localparam int COL_W  = sft_pkg::COL_W;
  localparam int VAL_W  = sft_pkg::VAL_W;
  localparam int NCW    = sft_pkg::NUM_COLS_W;
  localparam int WORD_W = sft_pkg::WORD_W;

  localparam int ENT_AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int LD_W   = $clog2(MAX_TERMS + 1);
  localparam int LOC_W  = $clog2(2 * MAX_TERMS + 1);
  localparam int DIM_AW = $clog2(MAX_DIM);
  localparam int P_W    = DIM_AW + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_PSUM = 4'd2;
  localparam logic [3:0] ST_SC_E = 4'd3;
  localparam logic [3:0] ST_SC_C = 4'd4;
  localparam logic [3:0] ST_SC_W = 4'd5;
  localparam logic [3:0] ST_EM_R = 4'd6;
  localparam logic [3:0] ST_EM_L = 4'd7;
  localparam logic [3:0] ST_EM_W = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [NCW-1:0]     num_cols_r;
  logic [LD_W-1:0]    loaded_r, loaded_nxt;
  logic [LD_W-1:0]    idx_r, idx_nxt;        // scatter and emit index
  logic [P_W-1:0]     p_r, p_nxt;            // running sum address
  logic [LOC_W-1:0]   run_r, run_nxt;
  logic [MAX_DIM-1:0] cvld_r, cvld_nxt;      // column table entry holds data
  logic               out_valid_r, out_valid_nxt;
  logic               out_last_r, out_last_nxt;

  logic [ROW_W-1:0]   itm_row_r;
  logic [COL_W-1:0]   itm_col_r;
  logic [VAL_W-1:0]   itm_val_r;
  logic               itm_last_r;
  logic               itm_keep_r;
  logic [WORD_W-1:0]  ent_r;
  logic [WORD_W-1:0]  out_word_r;

  logic [NCW-1:0]     ncols;
  logic               in_acc;
  logic [COL_W-1:0]   in_col;
  logic               in_keep;

  logic               ent_we;
  logic [ENT_AW-1:0]  ent_raddr;
  logic [WORD_W-1:0]  ent_rdata;
  logic               col_we;
  logic [DIM_AW-1:0]  col_waddr, col_raddr;
  logic [LOC_W-1:0]   col_wdata, col_rdata;
  logic               ob_we;
  logic [ENT_AW-1:0]  ob_raddr;
  logic [WORD_W-1:0]  ob_rdata;

  logic [DIM_AW-1:0]  q_idx;
  logic [LOC_W-1:0]   cnt_q;
  logic [LOC_W-1:0]   cnt_itm;
  logic [COL_W-1:0]   ent_col;
  logic [DIM_AW-1:0]  ent_cidx;

  assign ncols   = (num_cols_r > NCW'(MAX_DIM)) ? NCW'(MAX_DIM) : num_cols_r;
  assign in_acc  = in_tvalid && in_tready;
  assign in_col  = in_tdata[ROW_W +: COL_W];
  assign in_keep = ({1'b0, in_col} < ncols) && (loaded_r < LD_W'(MAX_TERMS));

  assign q_idx    = DIM_AW'(p_r - P_W'(1));
  assign cnt_q    = cvld_r[q_idx] ? col_rdata : '0;
  assign cnt_itm  = cvld_r[itm_col_r[DIM_AW-1:0]] ? col_rdata : '0;
  assign ent_col  = ent_r[ROW_W +: COL_W];
  assign ent_cidx = ent_col[DIM_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= sft_pkg::NUM_COLS_RST;
    end else if (cfg_wr_en) begin
      num_cols_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    run_nxt       = run_r;
    cvld_nxt      = cvld_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    ent_we        = 1'b0;
    col_we        = 1'b0;
    col_waddr     = itm_col_r[DIM_AW-1:0];
    col_wdata     = cnt_itm + LOC_W'(1);
    col_raddr     = in_col[DIM_AW-1:0];
    ob_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (itm_keep_r) begin
          col_we     = 1'b1;
          ent_we     = 1'b1;
          loaded_nxt = loaded_r + LD_W'(1);
          cvld_nxt[itm_col_r[DIM_AW-1:0]] = 1'b1;
        end
        if (itm_last_r) begin
          state_nxt = ST_PSUM;
          p_nxt     = '0;
          run_nxt   = '0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PSUM: begin
        // read column p while column p-1 turns into its start position
        col_raddr = p_r[DIM_AW-1:0];
        p_nxt     = p_r + P_W'(1);
        if (p_r != '0) begin
          col_we          = 1'b1;
          col_waddr       = q_idx;
          col_wdata       = run_r;
          cvld_nxt[q_idx] = 1'b1;
          if ({1'b0, q_idx} < P_W'(ncols)) begin
            run_nxt = run_r + cnt_q;
          end
        end
        if (p_r == P_W'(MAX_DIM)) begin
          idx_nxt   = '0;
          state_nxt = (loaded_r == '0) ? ST_DONE : ST_SC_E;
        end
      end
      ST_SC_E: begin
        state_nxt = ST_SC_C;
      end
      ST_SC_C: begin
        col_raddr = ent_rdata[ROW_W +: DIM_AW];
        state_nxt = ST_SC_W;
      end
      ST_SC_W: begin
        col_we    = 1'b1;
        col_waddr = ent_cidx;
        col_wdata = col_rdata + LOC_W'(1);
        ob_we     = (col_rdata < LOC_W'(MAX_TERMS));
        idx_nxt   = idx_r + LD_W'(1);
        if (idx_r + LD_W'(1) == loaded_r) begin
          idx_nxt   = '0;
          state_nxt = ST_EM_R;
        end else begin
          state_nxt = ST_SC_E;
        end
      end
      ST_EM_R: begin
        state_nxt = ST_EM_L;
      end
      ST_EM_L: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = (idx_r + LD_W'(1) == loaded_r);
        state_nxt     = ST_EM_W;
      end
      ST_EM_W: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          idx_nxt       = idx_r + LD_W'(1);
          state_nxt     = out_last_r ? ST_DONE : ST_EM_R;
        end
      end
      ST_DONE: begin
        cvld_nxt   = '0;
        loaded_nxt = '0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      idx_r       <= '0;
      p_r         <= '0;
      run_r       <= '0;
      cvld_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      idx_r       <= idx_nxt;
      p_r         <= p_nxt;
      run_r       <= run_nxt;
      cvld_r      <= cvld_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      itm_row_r  <= in_tdata[0 +: ROW_W];
      itm_col_r  <= in_col;
      itm_val_r  <= in_tdata[ROW_W + COL_W +: VAL_W];
      itm_last_r <= in_tlast;
      itm_keep_r <= in_keep;
    end
    if (state_r == ST_SC_C) begin
      ent_r <= ent_rdata;
    end
    if (state_r == ST_EM_L) begin
      out_word_r <= ob_rdata;
    end
  end

  assign ent_raddr = idx_r[ENT_AW-1:0];
  assign ob_raddr  = idx_r[ENT_AW-1:0];

  // entries in arrival order: row, col, value
  sft_ram #(
    .DEPTH(MAX_TERMS),
    .WIDTH(WORD_W),
    .AW   (ENT_AW)
  ) u_ent_ram (
    .clk    (clk),
    .wr_en  (ent_we),
    .wr_addr(loaded_r[ENT_AW-1:0]),
    .wr_data({itm_val_r, itm_col_r, itm_row_r}),
    .rd_addr(ent_raddr),
    .rd_data(ent_rdata)
  );

  // column counts, then start positions
  sft_ram #(
    .DEPTH(MAX_DIM),
    .WIDTH(LOC_W),
    .AW   (DIM_AW)
  ) u_col_ram (
    .clk    (clk),
    .wr_en  (col_we),
    .wr_addr(col_waddr),
    .wr_data(col_wdata),
    .rd_addr(col_raddr),
    .rd_data(col_rdata)
  );

  // transposed words in output order: source col, source row, value
  sft_ram #(
    .DEPTH(MAX_TERMS),
    .WIDTH(WORD_W),
    .AW   (ENT_AW)
  ) u_out_ram (
    .clk    (clk),
    .wr_en  (ob_we),
    .wr_addr(col_rdata[ENT_AW-1:0]),
    .wr_data({ent_r[ROW_W + COL_W +: VAL_W], ent_r[0 +: ROW_W], ent_col}),
    .rd_addr(ob_raddr),
    .rd_data(ob_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(sft_pkg::TDATA_W - WORD_W){1'b0}}, out_word_r};

  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_EM_W))
    else $error("result word shown outside emit phase");

  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= LD_W'(MAX_TERMS))
    else $error("entry count beyond store depth");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (cvld_r == '0) && (loaded_r == '0))
    else $error("column table not cleared after matrix");

  a_psum_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SC_E) |-> (cvld_r == '1))
    else $error("scatter began before every start position was written");

  a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && out_last_r) |=> (state_r == ST_DONE))
    else $error("matrix did not end after final word");

endmodule

`default_nettype wire

@@ hdl/sft_ram.sv @@
`default_nettype none

// One write port, one read port, registered read data.
module sft_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
